FILE: sv/hkrm_pkg.sv
// Shared types and constants of the held key report merger.
`default_nettype none

package hkrm_pkg;

   localparam int KEY_SLOTS = 6;

   localparam logic [1:0] CMD_PRESS   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   localparam logic [2:0] STATUS_APPLIED    = 3'd0;
   localparam logic [2:0] STATUS_NO_CHANGE  = 3'd1;
   localparam logic [2:0] STATUS_BAD_SOURCE = 3'd2;
   localparam logic [2:0] STATUS_BAD_REPORT = 3'd3;
   localparam logic [2:0] STATUS_ROLLOVER   = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] source;
      logic       report_valid;
      logic [7:0] in_modifier;
      logic       in_fn_key;
      logic [7:0] in_key0;
      logic [7:0] in_key1;
      logic [7:0] in_key2;
      logic [7:0] in_key3;
      logic [7:0] in_key4;
      logic [7:0] in_key5;
      logic [7:0] in_single_key;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_modifier;
      logic       out_fn_key;
      logic [7:0] out_key0;
      logic [7:0] out_key1;
      logic [7:0] out_key2;
      logic [7:0] out_key3;
      logic [7:0] out_key4;
      logic [7:0] out_key5;
      logic       held_updated;
      logic       snapshot_differs;
      logic       now_empty;
   } rsp_type;

   typedef struct packed {
      logic [7:0]                 single_key;
      logic                       fn_key;
      logic [7:0]                 modifier;
      logic [KEY_SLOTS-1:0][7:0]  keys;
   } held_entry_type;

   typedef struct packed {
      logic       init;
      logic       put;
      logic [7:0] key;
   } acc_cmd_type;

endpackage

`default_nettype wire

FILE: sv/hkrm_key_acc.sv
// Snapshot key accumulator: appends one key per cycle with duplicate check and overflow.
`default_nettype none

module hkrm_key_acc (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire hkrm_pkg::acc_cmd_type                 acc_cmd,
   output logic [hkrm_pkg::KEY_SLOTS-1:0][7:0]        acc_keys,
   output logic                                       acc_overflow
);
   import hkrm_pkg::*;

   logic [KEY_SLOTS-1:0][7:0] keys_ff, keys_in;
   logic [2:0]                count_ff, count_in;
   logic                      overflow_ff, overflow_in;
   logic                      match;

   always_comb begin
      match = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (keys_ff[i] == acc_cmd.key) begin
            match = 1'b1;
         end
      end
   end

   always_comb begin
      keys_in     = keys_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (acc_cmd.init) begin
         keys_in     = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (acc_cmd.put && (acc_cmd.key != 8'd0) && !match) begin
         if (count_ff == 3'(KEY_SLOTS)) begin
            overflow_in = 1'b1;
         end else begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
               if (count_ff == 3'(i)) begin
                  keys_in[i] = acc_cmd.key;
               end
            end
            count_in = count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff     <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         keys_ff     <= keys_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   assign acc_keys     = keys_ff;
   assign acc_overflow = overflow_ff;

endmodule

`default_nettype wire

FILE: sv/held_key_report_merger_core.sv
// Top level of the held key report merger: command sequencer, held report store and snapshot.
// Usage:
// A command beat is taken at a rising edge with start high and busy low; it carries
// press, release or clear for one source. Every command gives exactly one result beat,
// shown for one cycle with rsp_valid high; the receiver cannot hold it off.
// Commands that are refused or need no merge (bad source, bad report, no change, clear)
// answer in the cycle after acceptance and leave busy low.
// An applied press or release re-merges all sources through one shared key
// accumulator: an idle source is only looked up, an active source passes a read of
// the held store, six key slots, then the legacy key and modifiers, and a commit
// step ends the merge. Busy stays high until the result follows. The accumulator
// takes one key per cycle.
// Every result carries the current snapshot, after the command.
// Reset clears all active flags and the snapshot; the held store needs no clearing,
// since only active entries are ever used.
`default_nettype none

module held_key_report_merger_core #(
   parameter int SOURCES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire hkrm_pkg::req_type req_data,
   output logic                   rsp_valid,
   output hkrm_pkg::rsp_type      rsp_data
);
   import hkrm_pkg::*;

   localparam int SRC_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SLOT,
      S_LEGACY,
      S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   req_type                   req_ff, req_in;
   logic [SRC_W-1:0]          walk_ff, walk_in;
   logic [2:0]                slot_ff, slot_in;
   logic [SOURCES-1:0]        active_ff, active_in;
   logic [7:0]                snap_mod_ff, snap_mod_in;
   logic                      snap_fn_ff, snap_fn_in;
   logic [KEY_SLOTS-1:0][7:0] snap_keys_ff, snap_keys_in;
   logic [7:0]                acc_mod_ff, acc_mod_in;
   logic                      acc_fn_ff, acc_fn_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   held_entry_type            held_mem [SOURCES];
   held_entry_type            rd_entry_ff;
   held_entry_type            req_entry;
   held_entry_type            entry;
   logic                      mem_we;
   logic                      mem_rd_en;

   acc_cmd_type               acc_cmd;
   logic [KEY_SLOTS-1:0][7:0] acc_keys;
   logic                      acc_overflow;

   logic [SRC_W-1:0]          in_idx;
   logic [SRC_W-1:0]          s_idx;
   logic                      src_ok;
   logic                      usable;
   logic                      is_press;
   logic                      walk_last;
   logic                      cand_active;
   logic                      respond;
   logic [2:0]                status;
   logic                      st_ch;
   logic                      rep_ch;
   logic                      emp;

   hkrm_key_acc u_acc (
      .clock        (clock),
      .reset        (reset),
      .acc_cmd      (acc_cmd),
      .acc_keys     (acc_keys),
      .acc_overflow (acc_overflow)
   );

   assign in_idx    = req_data.source[SRC_W-1:0];
   assign s_idx     = req_ff.source[SRC_W-1:0];
   assign src_ok    = req_data.source < 8'(SOURCES);
   assign is_press  = req_ff.cmd == CMD_PRESS;
   assign walk_last = walk_ff == SRC_W'(SOURCES - 1);
   assign usable    = req_data.report_valid &&
                      ((req_data.in_modifier != 8'd0) || req_data.in_fn_key ||
                       (req_data.in_single_key != 8'd0) ||
                       ({req_data.in_key0, req_data.in_key1, req_data.in_key2,
                         req_data.in_key3, req_data.in_key4, req_data.in_key5} != 48'd0));

   assign req_entry.single_key = req_ff.in_single_key;
   assign req_entry.fn_key     = req_ff.in_fn_key;
   assign req_entry.modifier   = req_ff.in_modifier;
   assign req_entry.keys       = {req_ff.in_key5, req_ff.in_key4, req_ff.in_key3,
                                  req_ff.in_key2, req_ff.in_key1, req_ff.in_key0};

   assign entry       = (walk_ff == s_idx) ? req_entry : rd_entry_ff;
   assign cand_active = (walk_ff == s_idx) ? is_press : active_ff[walk_ff];

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      walk_in      = walk_ff;
      slot_in      = slot_ff;
      active_in    = active_ff;
      snap_mod_in  = snap_mod_ff;
      snap_fn_in   = snap_fn_ff;
      snap_keys_in = snap_keys_ff;
      acc_mod_in   = acc_mod_ff;
      acc_fn_in    = acc_fn_ff;
      acc_cmd      = '0;
      mem_we       = 1'b0;
      mem_rd_en    = 1'b0;
      respond      = 1'b0;
      status       = STATUS_NO_CHANGE;
      st_ch        = 1'b0;
      rep_ch       = 1'b0;
      emp          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            acc_cmd.init = 1'b1;
            acc_mod_in   = '0;
            acc_fn_in    = 1'b0;
            if (start) begin
               req_in  = req_data;
               respond = 1'b1;
               case (req_data.cmd) inside
                  CMD_PRESS, CMD_RELEASE: begin
                     if (!src_ok) begin
                        status = STATUS_BAD_SOURCE;
                     end else if ((req_data.cmd == CMD_PRESS) && !usable) begin
                        status = STATUS_BAD_REPORT;
                     end else if ((req_data.cmd == CMD_PRESS) == active_ff[in_idx]) begin
                        status = STATUS_NO_CHANGE;
                     end else begin
                        respond  = 1'b0;
                        walk_in  = '0;
                        state_in = S_READ;
                     end
                  end
                  CMD_CLEAR: begin
                     if (|active_ff) begin
                        active_in    = '0;
                        snap_mod_in  = '0;
                        snap_fn_in   = 1'b0;
                        snap_keys_in = '0;
                        status       = STATUS_APPLIED;
                        st_ch        = 1'b1;
                        rep_ch       = (snap_mod_ff != 8'd0) || snap_fn_ff ||
                                       (snap_keys_ff != '0);
                        emp          = 1'b1;
                     end
                  end
                  default: begin
                     status = STATUS_NO_CHANGE;
                  end
               endcase
            end
         end
         S_READ: begin
            mem_rd_en = 1'b1;
            if (cand_active) begin
               slot_in  = '0;
               state_in = S_SLOT;
            end else if (walk_last) begin
               state_in = S_FINISH;
            end else begin
               walk_in = walk_ff + SRC_W'(1);
            end
         end
         S_SLOT: begin
            acc_cmd.put = 1'b1;
            acc_cmd.key = entry.keys[slot_ff];
            if (slot_ff == 3'(KEY_SLOTS - 1)) begin
               state_in = S_LEGACY;
            end else begin
               slot_in = slot_ff + 3'd1;
            end
         end
         S_LEGACY: begin
            acc_cmd.put = entry.keys == '0;
            acc_cmd.key = entry.single_key;
            acc_mod_in  = acc_mod_ff | entry.modifier;
            acc_fn_in   = acc_fn_ff | entry.fn_key;
            if (walk_last) begin
               state_in = S_FINISH;
            end else begin
               walk_in  = walk_ff + SRC_W'(1);
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            respond  = 1'b1;
            state_in = S_IDLE;
            if (acc_overflow) begin
               status = STATUS_ROLLOVER;
            end else begin
               status           = STATUS_APPLIED;
               mem_we           = is_press;
               active_in[s_idx] = is_press;
               snap_mod_in      = acc_mod_ff;
               snap_fn_in       = acc_fn_ff;
               snap_keys_in     = acc_keys;
               st_ch            = 1'b1;
               rep_ch           = {acc_mod_ff, acc_fn_ff, acc_keys} !=
                                  {snap_mod_ff, snap_fn_ff, snap_keys_ff};
               emp              = !is_press && (acc_mod_ff == 8'd0) && !acc_fn_ff &&
                                  (acc_keys == '0);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in            = respond;
      rsp_in.status           = status;
      rsp_in.out_modifier     = snap_mod_in;
      rsp_in.out_fn_key       = snap_fn_in;
      rsp_in.out_key0         = snap_keys_in[0];
      rsp_in.out_key1         = snap_keys_in[1];
      rsp_in.out_key2         = snap_keys_in[2];
      rsp_in.out_key3         = snap_keys_in[3];
      rsp_in.out_key4         = snap_keys_in[4];
      rsp_in.out_key5         = snap_keys_in[5];
      rsp_in.held_updated     = st_ch;
      rsp_in.snapshot_differs = rep_ch;
      rsp_in.now_empty        = emp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ff       <= '0;
         walk_ff      <= '0;
         slot_ff      <= '0;
         active_ff    <= '0;
         snap_mod_ff  <= '0;
         snap_fn_ff   <= 1'b0;
         snap_keys_ff <= '0;
         acc_mod_ff   <= '0;
         acc_fn_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         req_ff       <= req_in;
         walk_ff      <= walk_in;
         slot_ff      <= slot_in;
         active_ff    <= active_in;
         snap_mod_ff  <= snap_mod_in;
         snap_fn_ff   <= snap_fn_in;
         snap_keys_ff <= snap_keys_in;
         acc_mod_ff   <= acc_mod_in;
         acc_fn_ff    <= acc_fn_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         held_mem[s_idx] <= req_entry;
      end
      if (mem_rd_en) begin
         rd_entry_ff <= held_mem[walk_ff];
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: sv/hkrm_checker.sv
// Port-level checker of the held key report merger and its bind to the top level.
`default_nettype none

module hkrm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire hkrm_pkg::rsp_type rsp_data
);
   import hkrm_pkg::*;

   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted command beat neither answered nor in progress");

   a_merge_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy fell without a result beat");

   a_refused_no_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_APPLIED)) |->
      (!rsp_data.held_updated && !rsp_data.snapshot_differs && !rsp_data.now_empty))
      else $error("refused command reports a change");

   a_empty_snapshot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.now_empty) |->
      ((rsp_data.out_modifier == 8'd0) && !rsp_data.out_fn_key &&
       (rsp_data.out_key0 == 8'd0) && (rsp_data.out_key5 == 8'd0)))
      else $error("empty flag set with a nonempty snapshot");

endmodule

bind held_key_report_merger_core hkrm_checker u_hkrm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: bench/tb_held_key_report_merger_core.sv
// Self-checking testbench for the held key report merger core with a built-in merge predictor.
`default_nettype none

module tb_held_key_report_merger_core;
   import hkrm_pkg::*;

   localparam int NUM_SOURCES = 8;
   localparam int MERGE_LATENCY = 8 * NUM_SOURCES + 2;
   localparam int RANDOM_ITEMS = 1925;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0]                modifier;
      logic                      fn_key;
      logic [KEY_SLOTS-1:0][7:0] keys;
   } snapshot_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   held_key_report_merger_core #(.SOURCES(NUM_SOURCES)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // Predicted held reports and snapshot.
   logic [KEY_SLOTS-1:0][7:0] bank_keys [NUM_SOURCES];
   logic [7:0]                bank_mod [NUM_SOURCES];
   logic                      bank_fn [NUM_SOURCES];
   logic [7:0]                bank_single [NUM_SOURCES];
   bit                        bank_on [NUM_SOURCES];
   snapshot_type              snapshot = '0;

   req_type stim_q [$];
   bit      drain_q [$];
   rsp_type pending_reports [$];

   int issue_count = 0;
   int accept_count = 0;
   int gap_left = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int n_checked = 0;
   int n_applied = 0;
   int n_rollover = 0;
   int n_refused = 0;
   int n_emptied = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
   end

   function automatic bit add_key(inout snapshot_type merged, inout int filled,
                                  input logic [7:0] key);
      if (key == 8'd0) return 1'b1;
      for (int i = 0; i < KEY_SLOTS; i++)
         if (merged.keys[i] == key) return 1'b1;
      if (filled >= KEY_SLOTS) return 1'b0;
      merged.keys[filled] = key;
      filled++;
      return 1'b1;
   endfunction

   function automatic bit merge_held(output snapshot_type merged);
      int filled;
      bit any_slot;
      merged = '0;
      filled = 0;
      for (int src = 0; src < NUM_SOURCES; src++) begin
         if (bank_on[src]) begin
            merged.modifier |= bank_mod[src];
            merged.fn_key |= bank_fn[src];
            any_slot = 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               if (bank_keys[src][i] != 8'd0) begin
                  any_slot = 1'b1;
                  if (!add_key(merged, filled, bank_keys[src][i])) return 1'b0;
               end
            end
            if (!any_slot && !add_key(merged, filled, bank_single[src])) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic rsp_type apply_command(input req_type r);
      snapshot_type prior;
      snapshot_type merged;
      logic [KEY_SLOTS-1:0][7:0] keys;
      logic [2:0] status;
      bit changed;
      bit differs;
      bit emptied;
      bit any_on;
      int s;
      rsp_type res;
      prior = snapshot;
      status = STATUS_NO_CHANGE;
      changed = 1'b0;
      differs = 1'b0;
      emptied = 1'b0;
      s = r.source;
      if (r.cmd == CMD_PRESS || r.cmd == CMD_RELEASE) begin
         if (r.source >= NUM_SOURCES) begin
            status = STATUS_BAD_SOURCE;
         end else if (r.cmd == CMD_PRESS) begin
            keys = {r.in_key5, r.in_key4, r.in_key3, r.in_key2, r.in_key1, r.in_key0};
            if (!r.report_valid || (r.in_modifier == 8'd0 && !r.in_fn_key &&
                r.in_single_key == 8'd0 && keys == '0)) begin
               status = STATUS_BAD_REPORT;
            end else if (!bank_on[s]) begin
               bank_keys[s] = keys;
               bank_mod[s] = r.in_modifier;
               bank_fn[s] = r.in_fn_key;
               bank_single[s] = r.in_single_key;
               bank_on[s] = 1'b1;
               if (!merge_held(merged)) begin
                  bank_on[s] = 1'b0;
                  status = STATUS_ROLLOVER;
               end else begin
                  snapshot = merged;
                  status = STATUS_APPLIED;
                  changed = 1'b1;
                  differs = (merged != prior);
               end
            end
         end else if (bank_on[s]) begin
            bank_on[s] = 1'b0;
            if (!merge_held(merged)) begin
               bank_on[s] = 1'b1;
               status = STATUS_ROLLOVER;
            end else begin
               snapshot = merged;
               status = STATUS_APPLIED;
               changed = 1'b1;
               differs = (merged != prior);
               emptied = (merged == '0);
            end
         end
      end else if (r.cmd == CMD_CLEAR) begin
         any_on = 1'b0;
         for (int i = 0; i < NUM_SOURCES; i++)
            if (bank_on[i]) any_on = 1'b1;
         if (any_on) begin
            for (int i = 0; i < NUM_SOURCES; i++) bank_on[i] = 1'b0;
            snapshot = '0;
            status = STATUS_APPLIED;
            changed = 1'b1;
            differs = (prior != '0);
            emptied = 1'b1;
         end
      end
      res.status = status;
      res.out_modifier = snapshot.modifier;
      res.out_fn_key = snapshot.fn_key;
      res.out_key0 = snapshot.keys[0];
      res.out_key1 = snapshot.keys[1];
      res.out_key2 = snapshot.keys[2];
      res.out_key3 = snapshot.keys[3];
      res.out_key4 = snapshot.keys[4];
      res.out_key5 = snapshot.keys[5];
      res.held_updated = changed;
      res.snapshot_differs = differs;
      res.now_empty = emptied;
      return res;
   endfunction

   function automatic string show_result(input rsp_type r);
      return $sformatf("status=%0d mod=%02h fn=%0b keys=%02h %02h %02h %02h %02h %02h %0b%0b%0b",
                       r.status, r.out_modifier, r.out_fn_key, r.out_key0, r.out_key1,
                       r.out_key2, r.out_key3, r.out_key4, r.out_key5, r.held_updated,
                       r.snapshot_differs, r.now_empty);
   endfunction

   function automatic req_type make_press(input logic [7:0] src, input logic valid,
                                          input logic [7:0] modifier, input logic fn,
                                          input logic [47:0] slots, input logic [7:0] single);
      req_type r;
      r = '0;
      r.cmd = CMD_PRESS;
      r.source = src;
      r.report_valid = valid;
      r.in_modifier = modifier;
      r.in_fn_key = fn;
      {r.in_key0, r.in_key1, r.in_key2, r.in_key3, r.in_key4, r.in_key5} = slots;
      r.in_single_key = single;
      return r;
   endfunction

   function automatic req_type make_plain(input logic [1:0] cmd, input logic [7:0] src);
      req_type r;
      r = '0;
      r.cmd = cmd;
      r.source = src;
      return r;
   endfunction

   function automatic logic [7:0] pick_key();
      if ($urandom_range(0, 1) == 0) return 8'd0;
      if ($urandom_range(0, 9) < 7) return 8'($urandom_range(4, 14));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] pick_source();
      if ($urandom_range(0, 99) < 92) return 8'($urandom_range(0, NUM_SOURCES - 1));
      return 8'($urandom_range(NUM_SOURCES, 255));
   endfunction

   function automatic req_type random_command();
      req_type r;
      logic [95:0] noise;
      int pick;
      pick = $urandom_range(0, 99);
      r = '0;
      if (pick < 45) begin
         r.cmd = CMD_PRESS;
         r.source = pick_source();
         r.report_valid = ($urandom_range(0, 99) < 95);
         r.in_modifier = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom());
         r.in_fn_key = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0) begin
            r.in_key0 = pick_key();
            r.in_key1 = pick_key();
            r.in_key2 = pick_key();
            r.in_key3 = pick_key();
            r.in_key4 = pick_key();
            r.in_key5 = pick_key();
         end
         r.in_single_key = pick_key();
      end else if (pick < 85) begin
         r.cmd = CMD_RELEASE;
         r.source = pick_source();
      end else if (pick < 92) begin
         r.cmd = CMD_CLEAR;
         r.source = 8'($urandom());
      end else if (pick < 95) begin
         r.cmd = CMD_UNUSED;
         r.source = 8'($urandom());
      end else begin
         noise = {$urandom(), $urandom(), $urandom()};
         r = noise[$bits(req_type)-1:0];
      end
      return r;
   endfunction

   function automatic int sender_gap(input int n);
      int pick;
      if ((n / 150) % 3 == 1) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   task automatic queue_item(input req_type r, input bit drain);
      stim_q.push_back(r);
      drain_q.push_back(drain);
   endtask

   // Driver: one beat per accepted command, with random gaps and occasional drains.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
      end else if (start && accept_count != issue_count) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else if (stim_q.size() == 0) begin
         start <= 1'b0;
      end else if (drain_q[0] && pending_reports.size() != 0) begin
         start <= 1'b0;
      end else begin
         req_data <= stim_q.pop_front();
         void'(drain_q.pop_front());
         start <= 1'b1;
         issue_count++;
         gap_left = sender_gap(issue_count);
      end
   end

   // Monitor: check the result beat of this cycle, then predict any command accepted now.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result beat: %s", show_result(rsp_data));
            end else begin
               want = pending_reports.pop_front();
               n_checked++;
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Result %0d differs", n_checked);
                     $display("   expected %s", show_result(want));
                     $display("   actual   %s", show_result(rsp_data));
                  end
               end
            end
         end
         if (start && !busy) begin
            want = apply_command(req_data);
            pending_reports.push_back(want);
            accept_count++;
            if (want.status == STATUS_APPLIED) n_applied++;
            if (want.status == STATUS_ROLLOVER) n_rollover++;
            if (want.status == STATUS_BAD_SOURCE || want.status == STATUS_BAD_REPORT)
               n_refused++;
            if (want.now_empty) n_emptied++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_reports.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      req_type r;
      int made;
      queue_item(make_plain(CMD_RELEASE, 8'd0), 1'b0);
      queue_item(make_plain(CMD_CLEAR, 8'd0), 1'b0);
      queue_item(make_plain(CMD_UNUSED, 8'd3), 1'b0);
      queue_item(make_press(8'd255, 1'b1, 8'h01, 1'b0, 48'h04, 8'd0), 1'b0);
      queue_item(make_press(8'(NUM_SOURCES), 1'b1, 8'h01, 1'b0, 48'h04, 8'd0), 1'b0);
      queue_item(make_plain(CMD_RELEASE, 8'd200), 1'b0);
      queue_item(make_press(8'd0, 1'b0, 8'hFF, 1'b1, 48'h040506070809, 8'd0), 1'b0);
      queue_item(make_press(8'd1, 1'b1, 8'h00, 1'b0, 48'h0, 8'd0), 1'b0);
      queue_item(make_press(8'd0, 1'b1, 8'hFF, 1'b1, 48'h040506070809, 8'd0), 1'b0);
      queue_item(make_press(8'd0, 1'b1, 8'h01, 1'b0, 48'h0A, 8'd0), 1'b0);
      queue_item(make_press(8'd1, 1'b1, 8'h00, 1'b0, 48'h0, 8'h2A), 1'b0);
      queue_item(make_press(8'd1, 1'b1, 8'h01, 1'b0, 48'h040500000000, 8'd0), 1'b0);
      queue_item(make_press(8'd2, 1'b1, 8'h00, 1'b0, 48'h0, 8'h05), 1'b0);
      queue_item(make_press(8'(NUM_SOURCES - 1), 1'b1, 8'h00, 1'b0, 48'hFF, 8'd0), 1'b0);
      queue_item(make_plain(CMD_RELEASE, 8'd0), 1'b0);
      queue_item(make_press(8'(NUM_SOURCES - 1), 1'b1, 8'h80, 1'b0, 48'hFF0000000000,
                            8'h11), 1'b0);
      queue_item(make_plain(CMD_RELEASE, 8'd1), 1'b0);
      queue_item(make_plain(CMD_RELEASE, 8'd2), 1'b0);
      queue_item(make_plain(CMD_RELEASE, 8'(NUM_SOURCES - 1)), 1'b0);
      queue_item(make_press(8'd3, 1'b1, 8'h01, 1'b0, 48'h0, 8'd0), 1'b0);
      queue_item(make_plain(CMD_RELEASE, 8'd3), 1'b0);
      queue_item(make_press(8'd4, 1'b1, 8'h00, 1'b1, 48'h0, 8'd0), 1'b0);
      queue_item(make_press(8'd5, 1'b1, 8'h00, 1'b0, 48'h0, 8'hFF), 1'b0);
      queue_item(make_press(8'd6, 1'b1, 8'h00, 1'b0, 48'h00000000FF00, 8'h00), 1'b0);
      queue_item(make_plain(CMD_CLEAR, 8'hFF), 1'b0);
      made = 0;
      while (made < RANDOM_ITEMS) begin
         r = random_command();
         queue_item(r, (made % 300) == 0);
         made++;
      end

      while (stim_q.size() != 0 || accept_count != issue_count) @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (MERGE_LATENCY + 4) @(posedge clock);

      $display("Checked %0d results: %0d applied, %0d rollovers, %0d bad source or report,",
               n_checked, n_applied, n_rollover, n_refused);
      $display("%0d left nothing held; %0d mismatches.", n_emptied, mismatches);
      if (mismatches == 0 && pending_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
sv/hkrm_pkg.sv
sv/hkrm_key_acc.sv
sv/held_key_report_merger_core.sv
sv/hkrm_checker.sv
bench/tb_held_key_report_merger_core.sv
